@@ rtl/assert_macros.svh @@
// Assertion macros shared by the level-of-detail selector RTL.
// Expects signals named clk and rst_n in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define LOD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define LOD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

@@ rtl/lod_pkg.sv @@
// Shared types and constants of the level-of-detail selector.
// No dependencies; used by every module of the block.
package lod_pkg;

    localparam int COORD_W  = 32;
    localparam int DIST_W   = 52;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 66;
    localparam int KTHR_W   = 55;
    localparam int LEVEL_W  = 3;
    localparam int RLEVEL_W = 4;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    // Screen scale breakpoints, Q16.16
    localparam logic [COORD_W-1:0] SCALE_THIRTYSECOND = 32'd2048;
    localparam logic [COORD_W-1:0] SCALE_SIXTEENTH    = 32'd4096;

    // Register indexes
    localparam logic [2:0] REG_VISIBLE_LIMIT = 3'd0;
    localparam logic [2:0] REG_LEVEL_COUNT   = 3'd1;
    localparam logic [2:0] REG_THRESHOLD_ONE = 3'd2;

    // Detail factor k/4
    typedef logic [1:0] factor_t;
    localparam factor_t FACTOR_HALF  = 2'd0;
    localparam factor_t FACTOR_THREE = 2'd1;
    localparam factor_t FACTOR_ONE   = 2'd2;

    // Axis select for the shared multiplier
    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // Selection outcome
    typedef logic [1:0] outcome_t;
    localparam outcome_t OUTCOME_INVISIBLE = 2'd0;
    localparam outcome_t OUTCOME_MATCH     = 2'd1;
    localparam outcome_t OUTCOME_FALLBACK  = 2'd2;

    localparam logic signed [RLEVEL_W-1:0] LEVEL_INVISIBLE = -4'sd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic signed [COORD_W-1:0] camera_z;
        logic signed [COORD_W-1:0] object_x;
        logic signed [COORD_W-1:0] object_y;
        logic signed [COORD_W-1:0] object_z;
        logic        [COORD_W-1:0] screen_scale;
    } item_t;

    typedef struct packed {
        logic        [DIST_W-1:0]   distance_squared;
        logic                       is_visible;
        logic signed [RLEVEL_W-1:0] reported_level;
        logic                       mesh_switched;
        logic        [LEVEL_W-1:0]  mesh_in_use;
    } result_t;

    typedef struct packed {
        logic               load;
        logic               mul_en;
        axis_t              mul_sel;
        logic               acc_en;
        logic               vis_en;
        logic               write;
        outcome_t           outcome;
        logic [LEVEL_W-1:0] level;
    } dp_cmd_t;

    typedef struct packed {
        logic visible;
        logic hit;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/lod_cfg.sv @@
// APB register file: visibility limit, level count and threshold memory.
// Depends on lod_pkg; threshold read port feeds the datapath level walk.
module lod_cfg import lod_pkg::*; #(
    parameter int MAX_LEVELS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic [LEVEL_W-1:0]    rd_level,
    output logic [DIST_W-1:0]     visible_limit,
    output logic [LEVEL_W-1:0]    level_count,
    output logic [DIST_W-1:0]     threshold
);

    localparam int AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

    logic [2:0]           idx;
    logic [2:0]           thr_idx;
    logic                 thr_in_range;
    logic                 wr;
    logic                 apb_setup;
    logic [AW-1:0]        a_addr;
    logic [AW-1:0]        b_addr;

    logic [DIST_W-1:0]    visible_limit_reg;
    logic [LEVEL_W-1:0]   level_count_reg;
    logic [MAX_LEVELS-1:0] thr_vld_reg;
    logic [DIST_W-1:0]    thr_mem [MAX_LEVELS];
    logic [DIST_W-1:0]    thr_a_reg;
    logic [DIST_W-1:0]    thr_b_reg;
    logic                 thr_a_vld_reg;
    logic                 thr_b_vld_reg;
    logic [2:0]           a_idx_reg;

    assign pready       = 1'b1;
    assign idx          = paddr[5:3];
    assign thr_idx      = idx - REG_THRESHOLD_ONE;
    assign thr_in_range = (idx >= REG_THRESHOLD_ONE) && (thr_idx < 3'(MAX_LEVELS));
    assign wr           = psel && penable && pwrite;
    assign apb_setup    = psel && !penable;
    assign a_addr       = thr_in_range ? AW'(thr_idx) : '0;
    assign b_addr       = (rd_level == '0) ? '0 : AW'(rd_level - 3'd1);

    // Scalar registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visible_limit_reg <= '0;
            level_count_reg   <= '0;
        end
        else if (wr)
        begin
            if (idx == REG_VISIBLE_LIMIT)
                visible_limit_reg <= pwdata[DIST_W-1:0];
            if (idx == REG_LEVEL_COUNT)
                level_count_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // Per-entry written flags; an unwritten threshold reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_vld_reg <= '0;
        else if (wr && thr_in_range)
            thr_vld_reg[a_addr] <= 1'b1;
    end

    // Threshold memory: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr && thr_in_range)
            thr_mem[a_addr] <= pwdata[DIST_W-1:0];
        thr_b_reg     <= thr_mem[b_addr];
        thr_b_vld_reg <= thr_vld_reg[b_addr];
        if (apb_setup)
        begin
            thr_a_reg     <= thr_mem[a_addr];
            thr_a_vld_reg <= thr_vld_reg[a_addr] && thr_in_range;
        end
    end

    // Read index captured in the setup phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_idx_reg <= REG_VISIBLE_LIMIT;
        else if (apb_setup)
            a_idx_reg <= idx;
    end

    // Read data mux
    always_comb
    begin
        unique case (a_idx_reg)
            REG_VISIBLE_LIMIT: prdata = APB_DATA_W'(visible_limit_reg);
            REG_LEVEL_COUNT:   prdata = APB_DATA_W'(level_count_reg);
            default:           prdata = thr_a_vld_reg ? APB_DATA_W'(thr_a_reg) : '0;
        endcase
    end

    assign visible_limit = visible_limit_reg;
    assign level_count   = level_count_reg;
    assign threshold     = thr_b_vld_reg ? thr_b_reg : '0;

endmodule

@@ rtl/lod_dp.sv @@
// Datapath: abs differences, shared squarer, distance accumulator, level compare,
// mesh state and result register. Depends on lod_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lod_dp import lod_pkg::*; #(
    parameter int MAX_LEVELS = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  item_t               item,
    input  dp_cmd_t             cmd,
    output dp_status_t          st,
    input  logic [DIST_W-1:0]   visible_limit,
    input  logic [DIST_W-1:0]   threshold,
    output logic                result_valid,
    input  logic                result_ready,
    output result_t             result
);

    function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                     input logic [COORD_W-1:0] b);
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    logic [COORD_W-1:0]  ad_reg [3];
    factor_t             factor_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                vis_reg;
    logic [LEVEL_W-1:0]  cur_mesh_reg;
    logic [RLEVEL_W-1:0] last_level_reg;
    logic                res_valid_reg;
    result_t             res_reg;

    logic [DIST_W-1:0]   dist_sq;
    logic [KTHR_W-1:0]   kthr;
    logic [KTHR_W-1:0]   dist4;
    logic [COORD_W-1:0]  mul_op;
    logic [LEVEL_W-1:0]  cur_mesh_next;
    logic [RLEVEL_W-1:0] last_level_next;
    logic                switched;
    factor_t             factor_in;

    // Detail factor from screen scale
    always_comb
    begin
        if (item.screen_scale <= SCALE_THIRTYSECOND)
            factor_in = FACTOR_HALF;
        else if (item.screen_scale <= SCALE_SIXTEENTH)
            factor_in = FACTOR_THREE;
        else
            factor_in = FACTOR_ONE;
    end

    // Capture on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ad_reg[AXIS_X] <= abs_diff(item.camera_x, item.object_x);
            ad_reg[AXIS_Y] <= abs_diff(item.camera_y, item.object_y);
            ad_reg[AXIS_Z] <= abs_diff(item.camera_z, item.object_z);
            factor_reg     <= factor_in;
        end
    end

    // Shared squarer and accumulator
    assign mul_op = ad_reg[cmd.mul_sel];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_op * mul_op;
        if (cmd.load)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    assign dist_sq = DIST_W'(acc_reg[ACC_W-1:16]);

    // Visibility
    always_ff @(posedge clk)
    begin
        if (cmd.vis_en)
            vis_reg <= (visible_limit == '0) || (dist_sq < visible_limit);
    end

    // Level test: k * threshold < 4 * distance
    always_comb
    begin
        case (factor_reg)
            FACTOR_HALF:  kthr = KTHR_W'(threshold) << 1;
            FACTOR_THREE: kthr = KTHR_W'(threshold) + (KTHR_W'(threshold) << 1);
            default:      kthr = KTHR_W'(threshold) << 2;
        endcase
        dist4 = KTHR_W'(dist_sq) << 2;
    end

    assign st.visible  = vis_reg;
    assign st.hit      = kthr < dist4;
    assign st.out_free = !res_valid_reg || result_ready;

    // Mesh state update
    always_comb
    begin
        cur_mesh_next   = cur_mesh_reg;
        last_level_next = last_level_reg;
        switched        = 1'b0;
        case (cmd.outcome)
            OUTCOME_INVISIBLE:
                last_level_next = LEVEL_INVISIBLE;
            OUTCOME_MATCH:
                if (cmd.level != cur_mesh_reg)
                begin
                    cur_mesh_next   = cmd.level;
                    last_level_next = RLEVEL_W'(cmd.level);
                    switched        = 1'b1;
                end
            OUTCOME_FALLBACK:
            begin
                cur_mesh_next   = '0;
                last_level_next = '0;
                switched        = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mesh_reg   <= '0;
            last_level_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                cur_mesh_reg   <= cur_mesh_next;
                last_level_reg <= last_level_next;
                res_valid_reg  <= 1'b1;
            end
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            res_reg.distance_squared <= dist_sq;
            res_reg.is_visible       <= vis_reg;
            res_reg.reported_level   <= last_level_next;
            res_reg.mesh_switched    <= switched;
            res_reg.mesh_in_use      <= cur_mesh_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    `LOD_ASSERT(a_switch_visible, (res_valid_reg && res_reg.mesh_switched) |-> res_reg.is_visible, "switch on invisible object")
    `LOD_ASSERT(a_invisible_level, (res_valid_reg && !res_reg.is_visible) |-> (res_reg.reported_level == LEVEL_INVISIBLE), "invisible object without level -1")
    `LOD_ASSERT(a_mesh_range, cur_mesh_reg <= 3'(MAX_LEVELS), "mesh in use beyond level range")

endmodule

@@ rtl/lod_ctrl.sv @@
// Controller: sequences capture, squaring, visibility, level walk and result write.
// Depends on lod_pkg and assert_macros.svh; drives lod_dp and the threshold read.
`include "assert_macros.svh"
module lod_ctrl import lod_pkg::*; #(
    parameter int MAX_LEVELS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [LEVEL_W-1:0] level_count,
    output logic [LEVEL_W-1:0] rd_level,
    output dp_cmd_t            cmd,
    input  dp_status_t         st
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_ACC  = 3'd4;
    localparam logic [2:0] S_VIS  = 3'd5;
    localparam logic [2:0] S_WALK = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]         state_reg,   state_next;
    logic [LEVEL_W-1:0] lvl_reg,     lvl_next;
    outcome_t           outcome_reg, outcome_next;
    logic [LEVEL_W-1:0] level_reg,   level_next;
    logic [LEVEL_W-1:0] count_sat;

    assign count_sat = (level_count > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : level_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            lvl_reg     <= '0;
            outcome_reg <= OUTCOME_INVISIBLE;
            level_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            lvl_reg     <= lvl_next;
            outcome_reg <= outcome_next;
            level_reg   <= level_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        lvl_next     = lvl_reg;
        outcome_next = outcome_reg;
        level_next   = level_reg;
        item_ready   = 1'b0;
        rd_level     = lvl_reg;
        cmd          = '0;
        cmd.outcome  = outcome_reg;
        cmd.level    = level_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = AXIS_X;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = AXIS_Y;
                cmd.acc_en  = 1'b1;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = AXIS_Z;
                cmd.acc_en  = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_VIS;
            end
            S_VIS:
            begin
                // Visibility compare; fetch threshold of the top level
                cmd.vis_en = 1'b1;
                rd_level   = count_sat;
                lvl_next   = count_sat;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // One level per cycle, highest first
                rd_level = (lvl_reg == '0) ? '0 : lvl_reg - 3'd1;
                if (!st.visible)
                begin
                    outcome_next = OUTCOME_INVISIBLE;
                    state_next   = S_DONE;
                end
                else if (lvl_reg == '0)
                begin
                    outcome_next = OUTCOME_FALLBACK;
                    state_next   = S_DONE;
                end
                else if (st.hit)
                begin
                    outcome_next = OUTCOME_MATCH;
                    level_next   = lvl_reg;
                    state_next   = S_DONE;
                end
                else if (lvl_reg == 3'd1)
                begin
                    outcome_next = OUTCOME_FALLBACK;
                    state_next   = S_DONE;
                end
                else
                    lvl_next = lvl_reg - 3'd1;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.write  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    `LOD_ASSERT(a_walk_range, (state_reg == S_WALK) |-> (lvl_reg <= 3'(MAX_LEVELS)), "walk level out of range")
    `LOD_ASSERT(a_write_free, cmd.write |-> st.out_free, "result written over pending transfer")
    `LOD_ASSERT(a_square_seq, (state_reg == S_MUL0) |=> ##2 (state_reg == S_ACC), "squaring sequence broken")

endmodule

@@ rtl/distance_lod_selector_unit.sv @@
// Top level of the distance-based level-of-detail selector.
// Depends on lod_pkg, lod_cfg, lod_ctrl and lod_dp.
//
// One item at a time: from transfer to result an item goes through the
// squaring of the three axis differences on a single shared 32x32 multiplier
// and its accumulator, the visibility compare, the level walk (one detail
// level tested at a time, down from level_count capped at MAX_LEVELS; it
// ends with no level tested when the object is invisible or no levels are
// in use), and the load of the output register. The input is ready again
// as soon as the result is loaded, even while that result still waits on
// result_ready; the load waits for the output register to be free. Registers
// sit at byte address 8*index on the 64-bit APB port; the user ensures they
// are written only while the block is idle, which the block does not enforce.
module distance_lod_selector_unit import lod_pkg::*; #(
    parameter int MAX_LEVELS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [DIST_W-1:0]  visible_limit;
    logic [LEVEL_W-1:0] level_count;
    logic [DIST_W-1:0]  threshold;
    logic [LEVEL_W-1:0] rd_level;
    dp_cmd_t            cmd;
    dp_status_t         st;

    lod_cfg #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .rd_level      (rd_level),
        .visible_limit (visible_limit),
        .level_count   (level_count),
        .threshold     (threshold)
    );

    lod_ctrl #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .level_count (level_count),
        .rd_level    (rd_level),
        .cmd         (cmd),
        .st          (st)
    );

    lod_dp #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .cmd           (cmd),
        .st            (st),
        .visible_limit (visible_limit),
        .threshold     (threshold),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

endmodule
